// ===== rtl/hystart_pp_slow_start_exit_assert.svh =====
// Assertion macros for the HyStart++ slow-start exit block.
// Included by the RTL files that carry concurrent assertions.
`ifndef HYSTART_PP_SLOW_START_EXIT_ASSERT_SVH
`define HYSTART_PP_SLOW_START_EXIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HSPP_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HSPP_ASSERT(lbl, prop, msg) \
  `HSPP_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define HSPP_ASSERT_AT(lbl, clk, rstn, prop, msg)
`define HSPP_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/hspp_pkg.sv =====
// Shared types and constants of the HyStart++ slow-start exit block.
// No dependencies.
`default_nettype none

package hspp_pkg;

  localparam int unsigned RttW   = 32;
  localparam int unsigned SeqW   = 62;
  localparam int unsigned ThW    = 20;
  localparam int unsigned CntW   = 8;
  localparam int unsigned ShiftW = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned InDataW  = 160;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 8;

  localparam logic [RttW-1:0] RttInf = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [CntW-1:0]   MinSamplesRst    = 8'd8;
  localparam logic [ThW-1:0]    ThreshFloorRst   = 20'd4000;
  localparam logic [ThW-1:0]    ThreshCeilRst    = 20'd16000;
  localparam logic [ShiftW-1:0] DivisorShiftRst  = 3'd3;
  localparam logic [CntW-1:0]   CssRoundLimitRst = 8'd5;

  typedef enum logic [2:0] {
    REG_MIN_SAMPLES     = 3'd0,
    REG_THRESH_FLOOR    = 3'd1,
    REG_THRESH_CEILING  = 3'd2,
    REG_DIVISOR_SHIFT   = 3'd3,
    REG_CSS_ROUND_LIMIT = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_ACK   = 1'b0,
    OP_START = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [CntW-1:0]   min_samples;
    logic [ThW-1:0]    thresh_floor;
    logic [ThW-1:0]    thresh_ceiling;
    logic [ShiftW-1:0] divisor_shift;
    logic [CntW-1:0]   css_round_limit;
  } cfg_t;

  typedef struct packed {
    opcode_e         opcode;
    logic [RttW-1:0] rtt_sample;
    logic            ack_known;
    logic [SeqW-1:0] acked_number;
    logic [SeqW-1:0] next_send_seq;
  } item_t;

  typedef struct packed {
    logic in_css;
    logic enter_avoidance;
    logic round_ended;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/hspp_core.sv =====
// Per-item round tracking, SS/CSS decision and result register.
// Depends on hspp_pkg and hystart_pp_slow_start_exit_assert.svh.
`default_nettype none
`include "hystart_pp_slow_start_exit_assert.svh"

module hspp_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hspp_pkg::cfg_t  cfg_i,
  input  wire logic            valid_i,
  input  wire hspp_pkg::item_t item_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output hspp_pkg::result_t    result_o,
  input  wire logic            ready_i
);

  logic [hspp_pkg::RttW-1:0] prev_round_min_q, prev_round_min_d;
  logic [hspp_pkg::RttW-1:0] round_min_q, round_min_d;
  logic [hspp_pkg::CntW-1:0] sample_count_q, sample_count_d;
  logic [hspp_pkg::SeqW-1:0] round_end_seq_q, round_end_seq_d;
  logic [hspp_pkg::RttW-1:0] css_baseline_q, css_baseline_d;
  logic [hspp_pkg::CntW-1:0] css_rounds_done_q, css_rounds_done_d;
  logic                      valid_q, valid_d;
  hspp_pkg::result_t         result_q, result_d;

  logic                      fire;
  logic                      is_start;
  logic [hspp_pkg::RttW-1:0] rm_upd;
  logic [hspp_pkg::CntW-1:0] sc_upd;
  logic                      enough;
  logic [hspp_pkg::RttW-1:0] th_shift;
  logic [hspp_pkg::ThW-1:0]  th_clamp;
  logic [hspp_pkg::ThW-1:0]  th;
  logic [hspp_pkg::RttW:0]   th_sum;
  logic [hspp_pkg::RttW-1:0] base_upd;
  logic                      round_end;
  logic                      css_now;
  logic [hspp_pkg::CntW-1:0] crd_upd;

  assign ready_o  = !valid_q || ready_i;
  assign fire     = valid_i && ready_o;
  assign is_start = (item_i.opcode == hspp_pkg::OP_START);

  always_comb begin
    rm_upd = (item_i.rtt_sample < round_min_q) ? item_i.rtt_sample : round_min_q;
    sc_upd = (sample_count_q == hspp_pkg::CntMax) ? sample_count_q
                                                  : sample_count_q + 8'd1;
    enough = (sc_upd >= cfg_i.min_samples);

    // delay threshold: clamp(prev_min >> shift) to [floor, ceiling], floor wins
    th_shift = prev_round_min_q >> cfg_i.divisor_shift;
    th_clamp = (th_shift > {12'd0, cfg_i.thresh_ceiling}) ? cfg_i.thresh_ceiling
                                                          : th_shift[hspp_pkg::ThW-1:0];
    th       = (th_clamp < cfg_i.thresh_floor) ? cfg_i.thresh_floor : th_clamp;
    th_sum   = {1'b0, prev_round_min_q} + {13'd0, th};

    base_upd = css_baseline_q;
    if (css_baseline_q == hspp_pkg::RttInf) begin
      if (enough && rm_upd != hspp_pkg::RttInf && prev_round_min_q != hspp_pkg::RttInf &&
          {1'b0, rm_upd} >= th_sum) begin
        base_upd = rm_upd;
      end
    end else if (enough && rm_upd < css_baseline_q) begin
      base_upd = hspp_pkg::RttInf;
    end

    round_end = item_i.ack_known && (item_i.acked_number >= round_end_seq_q);
    css_now   = (base_upd != hspp_pkg::RttInf);
    crd_upd   = css_rounds_done_q;
    if (css_now && css_rounds_done_q != hspp_pkg::CntMax) begin
      crd_upd = css_rounds_done_q + 8'd1;
    end
  end

  always_comb begin
    prev_round_min_d  = prev_round_min_q;
    round_min_d       = round_min_q;
    sample_count_d    = sample_count_q;
    round_end_seq_d   = round_end_seq_q;
    css_baseline_d    = css_baseline_q;
    css_rounds_done_d = css_rounds_done_q;
    valid_d           = valid_q && !ready_i;
    result_d          = result_q;
    if (fire) begin
      valid_d = 1'b1;
      if (is_start) begin
        prev_round_min_d  = hspp_pkg::RttInf;
        round_min_d       = hspp_pkg::RttInf;
        sample_count_d    = '0;
        round_end_seq_d   = item_i.next_send_seq;
        css_baseline_d    = hspp_pkg::RttInf;
        css_rounds_done_d = '0;
        result_d          = '0;
      end else begin
        css_baseline_d           = base_upd;
        result_d.in_css          = css_now;
        result_d.round_ended     = round_end;
        result_d.enter_avoidance = 1'b0;
        if (round_end) begin
          css_rounds_done_d        = crd_upd;
          result_d.enter_avoidance = css_now && (crd_upd >= cfg_i.css_round_limit);
          prev_round_min_d         = rm_upd;
          round_min_d              = hspp_pkg::RttInf;
          sample_count_d           = '0;
          round_end_seq_d          = item_i.next_send_seq;
        end else begin
          round_min_d    = rm_upd;
          sample_count_d = sc_upd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_round_min_q  <= hspp_pkg::RttInf;
      round_min_q       <= hspp_pkg::RttInf;
      sample_count_q    <= '0;
      round_end_seq_q   <= '0;
      css_baseline_q    <= hspp_pkg::RttInf;
      css_rounds_done_q <= '0;
      valid_q           <= 1'b0;
    end else begin
      prev_round_min_q  <= prev_round_min_d;
      round_min_q       <= round_min_d;
      sample_count_q    <= sample_count_d;
      round_end_seq_q   <= round_end_seq_d;
      css_baseline_q    <= css_baseline_d;
      css_rounds_done_q <= css_rounds_done_d;
      valid_q           <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  `HSPP_ASSERT(a_avoid_in_css,
    valid_q && result_q.enter_avoidance |-> result_q.in_css,
    "avoidance signaled outside CSS")
  `HSPP_ASSERT(a_round_open,
    fire && !is_start && round_end |=> sample_count_q == '0 && round_min_q == hspp_pkg::RttInf,
    "round end did not open a fresh round")
  `HSPP_ASSERT(a_start_clear,
    fire && is_start |=> css_baseline_q == hspp_pkg::RttInf && css_rounds_done_q == '0 &&
      prev_round_min_q == hspp_pkg::RttInf && !result_q.in_css,
    "start item did not clear round state")

endmodule

`default_nettype wire

// ===== rtl/hystart_pp_slow_start_exit.sv =====
// HyStart++ slow-start exit tracker for one path: top level.
// Input register, configuration registers and APB port; uses hspp_pkg and hspp_core.
//
// Usage: items arrive on the s_axis word channel (tuser: opcode, ack_known; tdata:
// rtt_sample, acked_number, next_send_seq). A start item clears all round state and
// opens a round ending at next_send_seq; an ack item folds its RTT sample into the
// round minimum, moves between SS and CSS, and closes a round once acked_number
// reaches the round end. Each item yields exactly one result word on m_axis
// (in_css, enter_avoidance, round_ended).
// Path: the result word passes the input register, then the result register.
// Throughput: one word per cycle while m_axis_tready_i is high; all per-item work
// is one compare/shift/add path between the input register and the result register.
// Stall: the result register holds while m_axis_tready_i is low; the input register,
// if empty, takes one more word, then s_axis_tready_o drops until the result is taken.
// Reset: clears round state to its idle values (minima at infinity, counters zero)
// and the config registers to defaults; pready is always high. The user must write
// configuration over APB only while no word is in flight; the block does not check.
`default_nettype none

module hystart_pp_slow_start_exit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [31:0] rtt_sample, [93:32] acked_number, [155:94] next_send_seq, [159:156] zero
  input  wire logic [hspp_pkg::InDataW-1:0] s_axis_tdata_i,
  // [0] opcode, [1] ack_known
  input  wire logic [hspp_pkg::InUserW-1:0] s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [0] in_css, [1] enter_avoidance, [2] round_ended, [7:3] zero
  output logic [hspp_pkg::OutDataW-1:0]     m_axis_tdata_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hspp_pkg::AddrW-1:0]   paddr,
  input  wire logic [hspp_pkg::DataW-1:0]   pwdata,
  output logic [hspp_pkg::DataW-1:0]        prdata,
  output logic                              pready
);

  hspp_pkg::cfg_t    cfg_q, cfg_d;
  logic              in_valid_q, in_valid_d;
  hspp_pkg::item_t   in_item_q, in_item_d;
  logic              core_ready;
  logic              s_acc;
  logic              cfg_wr;
  hspp_pkg::reg_idx_e reg_idx;
  hspp_pkg::result_t res;

  // APB
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = hspp_pkg::reg_idx_e'(paddr[hspp_pkg::AddrW-1:2]);

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (reg_idx)
      hspp_pkg::REG_MIN_SAMPLES: begin
        prdata = {24'd0, cfg_q.min_samples};
        if (cfg_wr) cfg_d.min_samples = pwdata[hspp_pkg::CntW-1:0];
      end
      hspp_pkg::REG_THRESH_FLOOR: begin
        prdata = {12'd0, cfg_q.thresh_floor};
        if (cfg_wr) cfg_d.thresh_floor = pwdata[hspp_pkg::ThW-1:0];
      end
      hspp_pkg::REG_THRESH_CEILING: begin
        prdata = {12'd0, cfg_q.thresh_ceiling};
        if (cfg_wr) cfg_d.thresh_ceiling = pwdata[hspp_pkg::ThW-1:0];
      end
      hspp_pkg::REG_DIVISOR_SHIFT: begin
        prdata = {29'd0, cfg_q.divisor_shift};
        if (cfg_wr) cfg_d.divisor_shift = pwdata[hspp_pkg::ShiftW-1:0];
      end
      hspp_pkg::REG_CSS_ROUND_LIMIT: begin
        prdata = {24'd0, cfg_q.css_round_limit};
        if (cfg_wr) cfg_d.css_round_limit = pwdata[hspp_pkg::CntW-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // input register
  assign s_axis_tready_o = !in_valid_q || core_ready;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = s_acc || (in_valid_q && !core_ready);
    in_item_d  = in_item_q;
    if (s_acc) begin
      in_item_d.opcode        = hspp_pkg::opcode_e'(s_axis_tuser_i[0]);
      in_item_d.ack_known     = s_axis_tuser_i[1];
      in_item_d.rtt_sample    = s_axis_tdata_i[31:0];
      in_item_d.acked_number  = s_axis_tdata_i[93:32];
      in_item_d.next_send_seq = s_axis_tdata_i[155:94];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q                <= 1'b0;
      cfg_q.min_samples         <= hspp_pkg::MinSamplesRst;
      cfg_q.thresh_floor        <= hspp_pkg::ThreshFloorRst;
      cfg_q.thresh_ceiling      <= hspp_pkg::ThreshCeilRst;
      cfg_q.divisor_shift       <= hspp_pkg::DivisorShiftRst;
      cfg_q.css_round_limit     <= hspp_pkg::CssRoundLimitRst;
    end else begin
      in_valid_q <= in_valid_d;
      cfg_q      <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
  end

  hspp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (in_valid_q),
    .item_i   (in_item_q),
    .ready_o  (core_ready),
    .valid_o  (m_axis_tvalid_o),
    .result_o (res),
    .ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {5'd0, res.round_ended, res.enter_avoidance, res.in_css};

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the HyStart++ slow-start exit tracker (hystart_pp_slow_start_exit).
// A clocked driver and monitor check every result word against an internal
// round and CSS tracker over several APB setups; uses hspp_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_valid = 1'b0;
  logic                          s_axis_tready_o;
  logic [hspp_pkg::InDataW-1:0]  s_data = '0;
  logic [hspp_pkg::InUserW-1:0]  s_user = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_ready = 1'b0;
  logic [hspp_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [hspp_pkg::AddrW-1:0]    paddr = '0;
  logic [hspp_pkg::DataW-1:0]    pwdata = '0;
  logic [hspp_pkg::DataW-1:0]    prdata;
  logic                          pready;

  hystart_pp_slow_start_exit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #4 clk_i = ~clk_i;

  hspp_pkg::item_t   item_q[$];
  hspp_pkg::result_t result_q[$];
  hspp_pkg::item_t   cur_item;
  int      send_idle = 0;
  int      recv_idle = 0;
  int      n_pushed = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_css = 0;
  int      n_avoid = 0;
  int      n_ended = 0;
  int      n_fail = 0;
  int      n_mismatch = 0;
  int      n_setups = 1;
  int unsigned cycles = 0;

  // tracker copy of configuration and round state
  hspp_pkg::cfg_t            cfg;
  logic [hspp_pkg::RttW-1:0] prev_min;
  logic [hspp_pkg::RttW-1:0] rnd_min;
  logic [hspp_pkg::CntW-1:0] n_samples;
  logic [hspp_pkg::SeqW-1:0] rnd_end;
  logic [hspp_pkg::RttW-1:0] baseline;
  logic [hspp_pkg::CntW-1:0] css_done;

  function automatic hspp_pkg::result_t track_slow_start(hspp_pkg::item_t it);
    hspp_pkg::result_t r;
    logic [63:0] th;
    logic [63:0] pm;
    logic [63:0] rm;
    r = '0;
    if (it.opcode == hspp_pkg::OP_START) begin
      prev_min  = hspp_pkg::RttInf;
      rnd_min   = hspp_pkg::RttInf;
      n_samples = '0;
      baseline  = hspp_pkg::RttInf;
      css_done  = '0;
      rnd_end   = it.next_send_seq;
      return r;
    end
    if (it.rtt_sample < rnd_min) rnd_min = it.rtt_sample;
    if (n_samples != hspp_pkg::CntMax) n_samples = n_samples + 1'b1;
    if (baseline == hspp_pkg::RttInf) begin
      if (n_samples >= cfg.min_samples && rnd_min != hspp_pkg::RttInf &&
          prev_min != hspp_pkg::RttInf) begin
        th = {32'd0, prev_min} >> cfg.divisor_shift;
        if (th > {44'd0, cfg.thresh_ceiling}) th = {44'd0, cfg.thresh_ceiling};
        if (th < {44'd0, cfg.thresh_floor}) th = {44'd0, cfg.thresh_floor};
        pm = {32'd0, prev_min};
        rm = {32'd0, rnd_min};
        if (rm >= pm + th) baseline = rnd_min;
      end
    end else if (n_samples >= cfg.min_samples && rnd_min < baseline) begin
      baseline = hspp_pkg::RttInf;
    end
    if (it.ack_known && it.acked_number >= rnd_end) begin
      if (baseline != hspp_pkg::RttInf) begin
        if (css_done != hspp_pkg::CntMax) css_done = css_done + 1'b1;
        if (css_done >= cfg.css_round_limit) r.enter_avoidance = 1'b1;
      end
      prev_min      = rnd_min;
      rnd_min       = hspp_pkg::RttInf;
      n_samples     = '0;
      rnd_end       = it.next_send_seq;
      r.round_ended = 1'b1;
    end
    r.in_css = (baseline != hspp_pkg::RttInf);
    return r;
  endfunction

  // driver: holds the word until accepted, tracks it on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        result_q.push_back(track_slow_start(cur_item));
        n_sent++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_item = item_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= {4'd0, cur_item.next_send_seq, cur_item.acked_number,
                      cur_item.rtt_sample};
          s_user  <= {cur_item.ack_known, cur_item.opcode};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    hspp_pkg::result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        n_css   += m_axis_tdata_o[0];
        n_avoid += m_axis_tdata_o[1];
        n_ended += m_axis_tdata_o[2];
        if (result_q.size() == 0) begin
          n_fail++;
          $display("result word with nothing pending: %b", m_axis_tdata_o[2:0]);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata_o[0] !== want.in_css ||
              m_axis_tdata_o[1] !== want.enter_avoidance ||
              m_axis_tdata_o[2] !== want.round_ended) begin
            n_fail++;
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("word %0d: exp css=%b avoid=%b ended=%b, got css=%b avoid=%b ended=%b",
                       n_checked, want.in_css, want.enter_avoidance, want.round_ended,
                       m_axis_tdata_o[0], m_axis_tdata_o[1], m_axis_tdata_o[2]);
          end
          n_checked++;
        end
      end
      m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [hspp_pkg::SeqW-1:0] rand_seq();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[hspp_pkg::SeqW-1:0];
  endfunction

  task automatic push_item(hspp_pkg::opcode_e op, logic [hspp_pkg::RttW-1:0] rtt,
                           logic known, logic [hspp_pkg::SeqW-1:0] ackn,
                           logic [hspp_pkg::SeqW-1:0] nxt);
    hspp_pkg::item_t it;
    it.opcode        = op;
    it.rtt_sample    = rtt;
    it.ack_known     = known;
    it.acked_number  = ackn;
    it.next_send_seq = nxt;
    item_q.push_back(it);
    n_pushed++;
  endtask

  task automatic apb_write(hspp_pkg::reg_idx_e idx, logic [hspp_pkg::DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      hspp_pkg::REG_MIN_SAMPLES:     cfg.min_samples     = val[hspp_pkg::CntW-1:0];
      hspp_pkg::REG_THRESH_FLOOR:    cfg.thresh_floor    = val[hspp_pkg::ThW-1:0];
      hspp_pkg::REG_THRESH_CEILING:  cfg.thresh_ceiling  = val[hspp_pkg::ThW-1:0];
      hspp_pkg::REG_DIVISOR_SHIFT:   cfg.divisor_shift   = val[hspp_pkg::ShiftW-1:0];
      hspp_pkg::REG_CSS_ROUND_LIMIT: cfg.css_round_limit = val[hspp_pkg::CntW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk_i); while (item_q.size() != 0 || s_valid || result_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic setup(logic [7:0] ms, logic [19:0] fl, logic [19:0] ce, logic [2:0] sh,
                       logic [7:0] lim);
    apb_write(hspp_pkg::REG_MIN_SAMPLES, {24'd0, ms});
    apb_write(hspp_pkg::REG_THRESH_FLOOR, {12'd0, fl});
    apb_write(hspp_pkg::REG_THRESH_CEILING, {12'd0, ce});
    apb_write(hspp_pkg::REG_DIVISOR_SHIFT, {29'd0, sh});
    apb_write(hspp_pkg::REG_CSS_ROUND_LIMIT, {24'd0, lim});
    n_setups++;
    @(negedge clk_i);
  endtask

  // start, then rounds of acks at an RTT level that drifts, jumps and drops (steady: jumps after the first round only)
  task automatic gen_flow(int rounds, int min_len, int max_len, bit steady);
    logic [hspp_pkg::SeqW-1:0] snd;
    logic [hspp_pkg::SeqW-1:0] rend_g;
    logic [hspp_pkg::SeqW-1:0] ackn;
    logic [63:0]     lv;
    logic [63:0]     rt;
    logic            known;
    int              len;
    snd = $urandom_range(0, 5) == 0 ? rand_seq()
                                    : hspp_pkg::SeqW'($urandom_range(1000, 100000));
    lv = ($urandom_range(0, 7) == 0 && !steady) ? 64'($urandom_range(32'hF0000000, 32'hFFFFFFF0))
                                                : 64'($urandom_range(1000, 300000));
    push_item(hspp_pkg::OP_START, $urandom(), 1'($urandom_range(0, 1)), rand_seq(), snd);
    for (int r = 0; r < rounds; r++) begin
      rend_g = snd;
      len = $urandom_range(min_len, max_len);
      for (int j = 0; j < len; j++) begin
        snd = snd + $urandom_range(1, 3);
        rt = steady ? lv : lv + $urandom_range(0, lv[31:0] >> 4);
        if (rt > 64'hFFFFFFFE) rt = 64'hFFFFFFFE;
        if (!steady && $urandom_range(0, 29) == 0) rt = {32'd0, hspp_pkg::RttInf};
        known = steady || $urandom_range(0, 19) != 0;
        ackn = (j == len - 1) ? rend_g + $urandom_range(0, 2) : rend_g - (len - j);
        push_item(hspp_pkg::OP_ACK, rt[31:0], known, ackn, snd);
      end
      if (steady) begin
        if (r == 0) lv = lv * 2 + 20000;
      end else begin
        case ($urandom_range(0, 9))
          5, 6: lv = lv * 2 + $urandom_range(0, 20000);
          7:    lv = lv + (lv >> 2) + 1100000;
          8, 9: lv = (lv >> 1) + 1;
          default: ;
        endcase
      end
      if (lv > 64'hFFFFFFF0) lv = 64'hFFFFFFF0;
    end
  endtask

  task automatic gen_random(int target);
    int stop;
    int max_len;
    stop = n_pushed + target;
    max_len = (cfg.min_samples > 12) ? 12 : int'(cfg.min_samples) + 3;
    while (n_pushed < stop) begin
      if ($urandom_range(0, 9) < 7) begin
        gen_flow($urandom_range(3, 8), 1, max_len, 1'b0);
      end else begin
        repeat ($urandom_range(1, 5))
          push_item($urandom_range(0, 7) == 0 ? hspp_pkg::OP_START : hspp_pkg::OP_ACK,
                    $urandom(), 1'($urandom_range(0, 1)), rand_seq(), rand_seq());
      end
    end
  endtask

  task automatic gen_directed();
    logic [hspp_pkg::SeqW-1:0] top;
    top = '1;
    push_item(hspp_pkg::OP_START, hspp_pkg::RttInf, 1'b1, top, '0);
    push_item(hspp_pkg::OP_ACK, '0, 1'b0, '0, '0);
    push_item(hspp_pkg::OP_ACK, hspp_pkg::RttInf, 1'b1, '0, '0);
    push_item(hspp_pkg::OP_ACK, 32'hFFFFFFFE, 1'b1, top, top);
    // near-infinite minima: sum with threshold must not wrap
    repeat (8) push_item(hspp_pkg::OP_ACK, 32'hFFFFFFFE, 1'b1, top - 1, top);
    push_item(hspp_pkg::OP_ACK, 32'hFFFFFFFE, 1'b1, top, top);
    push_item(hspp_pkg::OP_START, '0, 1'b0, '0, top);
    push_item(hspp_pkg::OP_ACK, 32'd1, 1'b0, top, '0);
    push_item(hspp_pkg::OP_ACK, 32'd1, 1'b1, top - 1, '0);
    push_item(hspp_pkg::OP_ACK, 32'h7FFFFFFF, 1'b1, top, 62'h2AAAAAAAAAAAAAAA);
  endtask

  initial begin
    cfg.min_samples     = hspp_pkg::MinSamplesRst;
    cfg.thresh_floor    = hspp_pkg::ThreshFloorRst;
    cfg.thresh_ceiling  = hspp_pkg::ThreshCeilRst;
    cfg.divisor_shift   = hspp_pkg::DivisorShiftRst;
    cfg.css_round_limit = hspp_pkg::CssRoundLimitRst;
    prev_min  = hspp_pkg::RttInf;
    rnd_min   = hspp_pkg::RttInf;
    n_samples = '0;
    rnd_end   = '0;
    baseline  = hspp_pkg::RttInf;
    css_done  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults
    send_idle <= 33;
    recv_idle <= 74;
    gen_directed();
    drain();
    gen_random(80);
    drain();

    setup(8'd1, 20'd0, 20'd1000000, 3'd0, 8'd1);
    gen_random(80);
    drain();

    send_idle <= 74;
    recv_idle <= 33;
    // floor above ceiling, sample count saturation in a long round
    setup(8'd255, 20'd1000000, 20'd0, 3'd7, 8'd255);
    gen_flow(2, 258, 262, 1'b0);
    gen_random(80);
    drain();

    setup(8'd0, 20'hFFFFF, 20'hFFFFF, 3'd7, 8'd0);
    gen_random(80);
    drain();

    send_idle <= 0;
    recv_idle <= 0;
    setup(8'd4, 20'd2000, 20'd8000, 3'd2, 8'd3);
    gen_random(80);
    drain();

    // long CSS stretch: round counter saturates
    setup(8'd1, 20'd100, 20'd200, 3'd5, 8'd255);
    gen_flow(300, 1, 1, 1'b1);
    gen_random(50);
    drain();

    repeat (10) @(posedge clk_i);
    if (result_q.size() != 0) n_fail++;
    $display("%0d words sent, %0d results checked across %0d configurations",
             n_sent, n_checked, n_setups);
    $display("results with CSS active: %0d, avoidance: %0d, round closes: %0d",
             n_css, n_avoid, n_ended);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hspp_pkg.sv
rtl/hspp_core.sv
rtl/hystart_pp_slow_start_exit.sv
bench/tb.sv
